### sv/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and constants of the byte memory cpu step core.
// ----------------------------------------------------------------------------
package bmc_pkg;

  localparam int MEM_BYTES_DEF = 8192;
  localparam int REG_COUNT_DEF = 6;
  localparam int STACK_TOP_DEF = 8192;

  // status codes
  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_HALT   = 3'd1;
  localparam logic [2:0] ST_MEMERR = 3'd2;
  localparam logic [2:0] ST_BADREG = 3'd3;
  localparam logic [2:0] ST_BADOP  = 3'd4;
  localparam logic [2:0] ST_PCOOB  = 3'd5;

  // opcodes
  localparam logic [7:0] OP_MOV_LO  = 8'h01;
  localparam logic [7:0] OP_MOV_HI  = 8'h03;
  localparam logic [7:0] OP_LDI8    = 8'h04;
  localparam logic [7:0] OP_LDI16   = 8'h05;
  localparam logic [7:0] OP_LDI32   = 8'h06;
  localparam logic [7:0] OP_LDB     = 8'h07;
  localparam logic [7:0] OP_LDW     = 8'h08;
  localparam logic [7:0] OP_LDD     = 8'h09;
  localparam logic [7:0] OP_STB     = 8'h0A;
  localparam logic [7:0] OP_STW     = 8'h0B;
  localparam logic [7:0] OP_STD     = 8'h0C;
  localparam logic [7:0] OP_ADD     = 8'h0D;
  localparam logic [7:0] OP_SUB     = 8'h0E;
  localparam logic [7:0] OP_INC     = 8'h0F;
  localparam logic [7:0] OP_DEC     = 8'h10;
  localparam logic [7:0] OP_CLR     = 8'h11;
  localparam logic [7:0] OP_AND     = 8'h12;
  localparam logic [7:0] OP_OR      = 8'h13;
  localparam logic [7:0] OP_XOR     = 8'h14;
  localparam logic [7:0] OP_ANDI    = 8'h15;
  localparam logic [7:0] OP_ORI     = 8'h16;
  localparam logic [7:0] OP_XORI    = 8'h17;
  localparam logic [7:0] OP_SHL     = 8'h18;
  localparam logic [7:0] OP_SHR     = 8'h19;
  localparam logic [7:0] OP_SAR     = 8'h1A;
  localparam logic [7:0] OP_SAL     = 8'h1B;
  localparam logic [7:0] OP_CMP     = 8'h1C;
  localparam logic [7:0] OP_JMP     = 8'h1D;
  localparam logic [7:0] OP_JE      = 8'h1E;
  localparam logic [7:0] OP_JNE     = 8'h1F;
  localparam logic [7:0] OP_JG      = 8'h20;
  localparam logic [7:0] OP_JL      = 8'h21;
  localparam logic [7:0] OP_JGE     = 8'h22;
  localparam logic [7:0] OP_JLE     = 8'h23;
  localparam logic [7:0] OP_JA      = 8'h24;
  localparam logic [7:0] OP_JB      = 8'h25;
  localparam logic [7:0] OP_PUSH    = 8'h26;
  localparam logic [7:0] OP_POP     = 8'h27;
  localparam logic [7:0] OP_CALL    = 8'h28;
  localparam logic [7:0] OP_RET     = 8'h29;
  localparam logic [7:0] OP_HALT    = 8'h2B;

  // flag bit positions
  localparam int FL_Z = 0;
  localparam int FL_S = 1;
  localparam int FL_C = 2;
  localparam int FL_O = 3;

  typedef enum logic [3:0] {
    S_CLEAR,   // clearing pass over memory after reset
    S_IDLE,
    S_FETCH,   // six byte reads
    S_DECODE,
    S_MEMRD,   // data reads
    S_MEMWR,   // data writes
    S_EXEC,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       clr_wr;     // write zero at clear counter
    logic       load_wr;    // write load byte
    logic       fetch_rd;   // read instruction byte at pc + cnt
    logic       data_rd;    // read data byte at addr + cnt
    logic       data_wr;    // write data byte at addr + cnt
    logic       cnt_clr;
    logic       decode;     // latch decoded operands and checks
    logic       exec;       // commit register, flag, pc, sp results
    logic       stop;       // latch fault status
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_done;
    logic [2:0] cnt;
    logic       rd_need;    // instruction reads memory
    logic       wr_need;    // instruction writes memory
    logic [2:0] nbytes;     // data access length
    logic [2:0] fault;      // fault found at decode, ST_RUN if none
    logic       stopped;
  } stat_t;

endpackage

### sv/bmc_if.sv
// ----------------------------------------------------------------------------
// bmc_if
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface bmc_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/bmc_ctrl.sv
// ----------------------------------------------------------------------------
// bmc_ctrl
// Sequencer: clearing pass, byte load, fetch, data access, execute, respond.
// ----------------------------------------------------------------------------
module bmc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bmc_pkg::stat_t stat,
  output bmc_pkg::cmd_t  cmd
);

  bmc_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= bmc_pkg::S_CLEAR;
    else     state <= state_next;
  end

  // next state; read states stay on after the last read for its byte to land
  always_comb begin
    state_next = state;
    case (state)
      bmc_pkg::S_CLEAR: if (stat.clr_done) state_next = bmc_pkg::S_IDLE;
      bmc_pkg::S_IDLE: begin
        if (in_valid) begin
          if (!in_action || stat.stopped) state_next = bmc_pkg::S_RESP;
          else                            state_next = bmc_pkg::S_FETCH;
        end
      end
      bmc_pkg::S_FETCH: if (stat.cnt == 3'd6) state_next = bmc_pkg::S_DECODE;
      bmc_pkg::S_DECODE: begin
        if (stat.fault != bmc_pkg::ST_RUN) state_next = bmc_pkg::S_RESP;
        else if (stat.rd_need)             state_next = bmc_pkg::S_MEMRD;
        else if (stat.wr_need)             state_next = bmc_pkg::S_MEMWR;
        else                               state_next = bmc_pkg::S_EXEC;
      end
      bmc_pkg::S_MEMRD:
        if (stat.cnt == stat.nbytes) state_next = bmc_pkg::S_EXEC;
      bmc_pkg::S_MEMWR:
        if (stat.cnt == stat.nbytes - 3'd1) state_next = bmc_pkg::S_EXEC;
      bmc_pkg::S_EXEC: state_next = bmc_pkg::S_RESP;
      bmc_pkg::S_RESP: if (out_ready) state_next = bmc_pkg::S_IDLE;
      default: state_next = bmc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      bmc_pkg::S_CLEAR: cmd.clr_wr = 1'b1;
      bmc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.cnt_clr = 1'b1;
        cmd.load_wr = in_valid && !in_action;
      end
      bmc_pkg::S_FETCH: cmd.fetch_rd = 1'b1;
      bmc_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        cmd.cnt_clr = 1'b1;
        cmd.stop = stat.fault != bmc_pkg::ST_RUN;
      end
      bmc_pkg::S_MEMRD: cmd.data_rd = 1'b1;
      bmc_pkg::S_MEMWR: cmd.data_wr = 1'b1;
      bmc_pkg::S_EXEC: cmd.exec = 1'b1;
      bmc_pkg::S_RESP: out_valid = 1'b1;
      default: ;
    endcase
  end

  // a result is offered only after a transaction was taken
  a_resp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == bmc_pkg::S_IDLE ||
      $past(state) == bmc_pkg::S_EXEC || $past(state) == bmc_pkg::S_DECODE))
    else $error("result without work");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_decode_once: assert property (@(posedge clk) disable iff (rst)
    cmd.decode |=> !cmd.decode) else $error("decode repeated");

endmodule

### sv/bmc_dp.sv
// ----------------------------------------------------------------------------
// bmc_dp
// Datapath: byte memory, register file, decode, alu, pc and sp.
// ----------------------------------------------------------------------------
module bmc_dp #(
  parameter int MEM_BYTES = bmc_pkg::MEM_BYTES_DEF,
  parameter int REG_COUNT = bmc_pkg::REG_COUNT_DEF,
  parameter int STACK_TOP = bmc_pkg::STACK_TOP_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  bmc_pkg::cmd_t  cmd,
  output bmc_pkg::stat_t stat,
  input  logic [12:0]    load_address,
  input  logic [7:0]     load_byte,
  output logic [2:0]     status,
  output logic [15:0]    program_counter,
  output logic [15:0]    stack_pointer,
  output logic [31:0]    register_zero,
  output logic [3:0]     flag_bits
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = $clog2(REG_COUNT);
  localparam logic [16:0] MEM_LIM = 17'(MEM_BYTES);

  logic [7:0]  mem [MEM_BYTES];
  logic [AW:0] clr_cnt;
  logic [2:0]  cnt;
  logic [15:0] pc, sp;
  logic [31:0] regs [REG_COUNT];
  logic [3:0]  flags;
  logic [2:0]  stop_code;
  logic [7:0]  ibuf [6];
  logic [31:0] dbuf;
  logic [7:0]  rd_byte;

  // decoded fields
  logic [7:0]  op, ra8, b28, b38;
  logic [31:0] imm;
  logic [15:0] tgt, nxt, addr, sp_dec;
  logic [RW-1:0] ra, rb2, rb3;
  logic [31:0] va, vb, vc;
  logic [2:0]  nb;
  logic        rd_need, wr_need;
  logic [2:0]  fault;
  logic        op_ok;
  logic        need_ra, need_b2, need_b3;
  logic        is_ld, is_st, is_stk;

  // latched decode
  logic [7:0]    op_q;
  logic [RW-1:0] ra_q, rb2_q;
  logic [31:0]   va_q, vb_q, imm_q;
  logic [15:0]   addr_q, nxt_q, tgt_q;
  logic [2:0]    nb_q;
  logic          rd_q, wr_q;

  // fetch byte count check over all six bytes
  logic [16:0] pc_end;
  logic        fetch_ok;
  assign pc_end   = {1'b0, pc} + 17'd6;
  assign fetch_ok = pc_end <= MEM_LIM;

  assign op  = ibuf[0];
  assign ra8 = ibuf[1];
  assign b28 = ibuf[2];
  assign b38 = ibuf[3];
  assign imm = {ibuf[5], ibuf[4], ibuf[3], ibuf[2]};
  assign tgt = imm[15:0];
  assign nxt = pc + 16'd6;
  assign ra  = ra8[RW-1:0];
  assign rb2 = b28[RW-1:0];
  assign rb3 = b38[RW-1:0];
  assign va  = regs[ra];
  assign vb  = regs[rb2];
  assign vc  = regs[rb3];
  assign sp_dec = sp - 16'd2;

  // decode
  always_comb begin
    op_ok = !(op == 8'h00 || op == 8'h2A || op > bmc_pkg::OP_HALT);
    need_ra = op <= bmc_pkg::OP_CMP || op == bmc_pkg::OP_PUSH || op == bmc_pkg::OP_POP;
    need_b2 = op == bmc_pkg::OP_CMP || op == bmc_pkg::OP_ADD || op == bmc_pkg::OP_SUB ||
              op == bmc_pkg::OP_AND || op == bmc_pkg::OP_OR || op == bmc_pkg::OP_XOR;
    need_b3 = op <= bmc_pkg::OP_MOV_HI;
    is_ld = op >= bmc_pkg::OP_LDB && op <= bmc_pkg::OP_LDD;
    is_st = op >= bmc_pkg::OP_STB && op <= bmc_pkg::OP_STD;
    is_stk = op >= bmc_pkg::OP_PUSH && op <= bmc_pkg::OP_RET;
    nb = 3'd2;
    addr = tgt;
    if (op == bmc_pkg::OP_LDB || op == bmc_pkg::OP_STB) nb = 3'd1;
    else if (op == bmc_pkg::OP_LDD || op == bmc_pkg::OP_STD) nb = 3'd4;
    if (op == bmc_pkg::OP_PUSH || op == bmc_pkg::OP_CALL) addr = sp_dec;
    else if (op == bmc_pkg::OP_POP || op == bmc_pkg::OP_RET) addr = sp;
    rd_need = is_ld || op == bmc_pkg::OP_POP || op == bmc_pkg::OP_RET;
    wr_need = is_st || op == bmc_pkg::OP_PUSH || op == bmc_pkg::OP_CALL;
    if (!fetch_ok) fault = bmc_pkg::ST_MEMERR;
    else if (!op_ok) fault = bmc_pkg::ST_BADOP;
    else if (op == bmc_pkg::OP_HALT) fault = bmc_pkg::ST_HALT;
    else if ((need_ra && 32'(ra8) >= REG_COUNT) || (need_b2 && 32'(b28) >= REG_COUNT) ||
             (need_b3 && 32'(b38) >= REG_COUNT)) fault = bmc_pkg::ST_BADREG;
    else if ((is_ld || is_st || is_stk) &&
             ({1'b0, addr} + 17'(nb)) > MEM_LIM) fault = bmc_pkg::ST_MEMERR;
    else fault = bmc_pkg::ST_RUN;
  end

  // memory with clearing pass; one byte port shared by all accesses
  logic [AW-1:0] m_addr;
  logic [15:0]   acc_addr;
  logic [15:0]   load_addr_ext;
  logic [7:0]    wr_data;
  assign load_addr_ext = {3'b000, load_address};
  always_comb begin
    acc_addr = cmd.fetch_rd ? pc + 16'(cnt) : addr_q + 16'(cnt);
    m_addr = acc_addr[AW-1:0];
    case (cnt[1:0])
      2'd0: wr_data = dbuf[7:0];
      2'd1: wr_data = dbuf[15:8];
      2'd2: wr_data = dbuf[23:16];
      default: wr_data = dbuf[31:24];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem[clr_cnt[AW-1:0]] <= 8'h00;
    else if (cmd.load_wr && 32'(load_address) < MEM_BYTES)
      mem[load_addr_ext[AW-1:0]] <= load_byte;
    else if (cmd.data_wr) mem[m_addr] <= wr_data;
    rd_byte <= mem[m_addr];
  end

  // clear counter
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_wr) clr_cnt <= clr_cnt + 1'b1;
  end

  // byte counter; a read lands in the next cycle at cnt-1, the last count only waits
  logic       rd_pend;
  logic [2:0] rd_idx;
  logic       rd_fetch;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (cmd.fetch_rd && fetch_ok && cnt < 3'd6) ||
                 (cmd.data_rd && cnt < nb_q);
      rd_fetch <= cmd.fetch_rd;
      rd_idx <= cnt;
      if (cmd.cnt_clr) cnt <= '0;
      else if (cmd.fetch_rd || cmd.data_rd || cmd.data_wr) cnt <= cnt + 3'd1;
    end
  end

  // capture read bytes
  always_ff @(posedge clk) begin
    if (rd_pend && rd_fetch) ibuf[rd_idx] <= rd_byte;
    if (rd_pend && !rd_fetch) case (rd_idx[1:0])
      2'd0: dbuf[7:0] <= rd_byte;
      2'd1: dbuf[15:8] <= rd_byte;
      2'd2: dbuf[23:16] <= rd_byte;
      default: dbuf[31:24] <= rd_byte;
    endcase
    if (cmd.decode) begin
      op_q <= op; ra_q <= ra; rb2_q <= rb2; imm_q <= imm;
      va_q <= (need_b3) ? vc : va; vb_q <= vb;
      addr_q <= addr; nxt_q <= nxt; tgt_q <= tgt; nb_q <= nb;
      rd_q <= rd_need; wr_q <= wr_need;
      if (rd_need) dbuf <= '0;
      else if (op == bmc_pkg::OP_CALL) dbuf <= {16'h0, nxt};
      else dbuf <= va;
    end
  end

  // execute
  logic [31:0] d, ld_val;
  logic [RW-1:0] wdst;
  logic        wen, zf_en, take;
  logic [15:0] pc_n, sp_n;
  logic [3:0]  fl_n;
  logic [32:0] cmp_d;
  logic        zf, sf, cf, of;
  assign zf = flags[bmc_pkg::FL_Z];
  assign sf = flags[bmc_pkg::FL_S];
  assign cf = flags[bmc_pkg::FL_C];
  assign of = flags[bmc_pkg::FL_O];
  always_comb begin
    ld_val = dbuf;
    d = '0; wdst = ra_q; wen = 1'b0; zf_en = 1'b0;
    pc_n = nxt_q; sp_n = sp; fl_n = flags;
    cmp_d = {1'b0, va_q} - {1'b0, vb_q};
    take = 1'b0;
    case (op_q)
      bmc_pkg::OP_JMP: take = 1'b1;
      bmc_pkg::OP_JE:  take = zf;
      bmc_pkg::OP_JNE: take = !zf;
      bmc_pkg::OP_JG:  take = !zf && (sf == of);
      bmc_pkg::OP_JL:  take = sf != of;
      bmc_pkg::OP_JGE: take = sf == of;
      bmc_pkg::OP_JLE: take = zf || (sf != of);
      bmc_pkg::OP_JA:  take = !cf && !zf;
      bmc_pkg::OP_JB:  take = cf;
      default: take = 1'b0;
    endcase
    if (op_q <= bmc_pkg::OP_MOV_HI) begin wen = 1'b1; d = va_q; end
    else if (op_q == bmc_pkg::OP_LDI8) begin wen = 1'b1; d = {24'h0, imm_q[7:0]}; end
    else if (op_q == bmc_pkg::OP_LDI16) begin wen = 1'b1; d = {16'h0, imm_q[15:0]}; end
    else if (op_q == bmc_pkg::OP_LDI32) begin wen = 1'b1; d = imm_q; end
    else if (op_q <= bmc_pkg::OP_LDD) begin wen = 1'b1; d = ld_val; end
    else if (op_q <= bmc_pkg::OP_STD) wen = 1'b0;
    else if (op_q == bmc_pkg::OP_ADD || op_q == bmc_pkg::OP_SUB) begin
      wen = 1'b1; zf_en = 1'b1; wdst = rb2_q;
      d = (op_q == bmc_pkg::OP_ADD) ? vb_q + va_q : vb_q - va_q;
    end
    else if (op_q == bmc_pkg::OP_INC) begin wen = 1'b1; d = va_q + 32'd1; end
    else if (op_q == bmc_pkg::OP_DEC) begin wen = 1'b1; d = va_q - 32'd1; end
    else if (op_q == bmc_pkg::OP_CLR) begin wen = 1'b1; d = '0; end
    else if (op_q <= bmc_pkg::OP_XOR) begin
      wen = 1'b1; zf_en = 1'b1; wdst = rb2_q;
      d = (op_q == bmc_pkg::OP_AND) ? va_q & vb_q :
          (op_q == bmc_pkg::OP_OR) ? va_q | vb_q : va_q ^ vb_q;
    end
    else if (op_q <= bmc_pkg::OP_XORI) begin
      wen = 1'b1; zf_en = 1'b1;
      d = (op_q == bmc_pkg::OP_ANDI) ? va_q & imm_q :
          (op_q == bmc_pkg::OP_ORI) ? va_q | imm_q : va_q ^ imm_q;
    end
    else if (op_q <= bmc_pkg::OP_SAL) begin
      wen = 1'b1;
      if (op_q == bmc_pkg::OP_SHR) d = (imm_q >= 32'd32) ? '0 : va_q >> imm_q[4:0];
      else if (op_q == bmc_pkg::OP_SAR)
        d = (imm_q >= 32'd32) ? {32{va_q[31]}} : 32'($signed(va_q) >>> imm_q[4:0]);
      else d = (imm_q >= 32'd32) ? '0 : va_q << imm_q[4:0];
    end
    else if (op_q == bmc_pkg::OP_CMP) begin
      fl_n[bmc_pkg::FL_Z] = cmp_d[31:0] == '0;
      fl_n[bmc_pkg::FL_S] = cmp_d[31];
      fl_n[bmc_pkg::FL_C] = cmp_d[32];
      fl_n[bmc_pkg::FL_O] = ((va_q[31] ^ vb_q[31]) & (va_q[31] ^ cmp_d[31]));
    end
    else if (op_q <= bmc_pkg::OP_JB) pc_n = take ? tgt_q : nxt_q;
    else if (op_q == bmc_pkg::OP_PUSH) sp_n = addr_q;
    else if (op_q == bmc_pkg::OP_CALL) begin sp_n = addr_q; pc_n = tgt_q; end
    else if (op_q == bmc_pkg::OP_POP) begin
      sp_n = sp + 16'd2; wen = 1'b1; zf_en = 1'b1; d = {16'h0, ld_val[15:0]};
    end
    else begin sp_n = sp + 16'd2; pc_n = ld_val[15:0]; end
    if (zf_en) fl_n[bmc_pkg::FL_Z] = d == '0;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      sp <= 16'(STACK_TOP);
      flags <= '0;
      stop_code <= bmc_pkg::ST_RUN;
      for (int i = 0; i < REG_COUNT; i++) regs[i] <= '0;
    end else if (cmd.stop) begin
      stop_code <= fault;
    end else if (cmd.exec) begin
      pc <= pc_n;
      sp <= sp_n;
      flags <= fl_n;
      if (wen) regs[wdst] <= d;
      if ({16'h0, pc_n} >= 32'(MEM_BYTES)) stop_code <= bmc_pkg::ST_PCOOB;
    end
  end

  assign stat.clr_done = clr_cnt == (AW+1)'(MEM_BYTES - 1);
  assign stat.cnt = cnt;
  assign stat.rd_need = rd_need;
  assign stat.wr_need = wr_need;
  assign stat.nbytes = cmd.decode ? nb : nb_q;
  assign stat.fault = fault;
  assign stat.stopped = stop_code != bmc_pkg::ST_RUN;

  assign status = stop_code;
  assign program_counter = pc;
  assign stack_pointer = sp;
  assign register_zero = regs[0];
  assign flag_bits = flags;

  // a fault found at decode leaves the program counter unchanged
  a_fault_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    cmd.stop |=> $stable(pc)) else $error("pc moved on fault");
  a_access_flags: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !(rd_q && wr_q)) else $error("read and write in one op");
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    (stop_code != bmc_pkg::ST_RUN) |=> (stop_code == $past(stop_code)))
    else $error("stop code changed");

endmodule

### sv/byte_memory_cpu_step.sv
// ----------------------------------------------------------------------------
// byte_memory_cpu_step
// Small byte memory cpu: loads program bytes or steps one instruction.
// ----------------------------------------------------------------------------
// After reset the core clears its byte memory one byte a cycle (MEM_BYTES
// bytes, 8192 by default) before taking any transaction. A load, or a step
// while the core is stopped, goes from accept straight to respond. An
// instruction is paced by the single byte port of the memory and its
// registered read: accept, fetch (six reads and a wait for the last byte to
// land), decode, a data access of up to four bytes if any (a write of its
// length, a read with one more wait for its last byte), execute and respond.
// A fault found at decode goes straight to respond. A stalled result waits
// in respond until taken. One result is returned per transaction.
module byte_memory_cpu_step #(
  parameter int MEM_BYTES = bmc_pkg::MEM_BYTES_DEF,
  parameter int REG_COUNT = bmc_pkg::REG_COUNT_DEF,
  parameter int STACK_TOP = bmc_pkg::STACK_TOP_DEF
) (
  input  logic   clk,
  input  logic   rst,
  bmc_if.sink    in_ch,
  bmc_if.source  out_ch
);

  bmc_pkg::cmd_t  cmd;
  bmc_pkg::stat_t stat;
  logic [2:0]  status;
  logic [15:0] program_counter, stack_pointer;
  logic [31:0] register_zero;
  logic [3:0]  flag_bits;

  // controller
  bmc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_action(in_ch.payload[0]), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  // datapath
  bmc_dp #(.MEM_BYTES(MEM_BYTES), .REG_COUNT(REG_COUNT), .STACK_TOP(STACK_TOP)) u_dp (
    .clk, .rst, .cmd, .stat,
    .load_address(in_ch.payload[13:1]), .load_byte(in_ch.payload[21:14]),
    .status, .program_counter, .stack_pointer, .register_zero, .flag_bits
  );

  assign out_ch.payload = {flag_bits, register_zero, stack_pointer, program_counter, status};

endmodule
